FILE: rtl/cbse_pkg.sv
// ----------------------------------------------------------------------------
// cbse_pkg
// Shared constants, types and helpers for the cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package cbse_pkg;

  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned CoefWidth  = 16;
  localparam int unsigned NumRegs    = 8;
  localparam int unsigned ParamWidth = 27;

  localparam logic [31:0] BasisReset [NumRegs] = '{
    32'd4026533205, 32'd4205514752, 32'd5461, 32'd268492800,
    32'd268436821, 32'd4026535936, 32'd0, 32'd89456640
  };

  localparam logic [1:0] StatusEval   = 2'd0;
  localparam logic [1:0] StatusFew    = 2'd1;
  localparam logic [1:0] StatusAppend = 2'd2;
  localparam logic [1:0] StatusFull   = 2'd3;

  localparam logic [1:0] KindPos  = 2'd0;
  localparam logic [1:0] KindTan  = 2'd1;
  localparam logic [1:0] KindCurv = 2'd2;

  localparam logic ActAppend = 1'b0;

  // One basis coefficient as scaled for the derivative kinds: coefficients in Q.13 times powers in Q.16.
  typedef logic signed [19:0] coef_t;

endpackage

FILE: rtl/cbse_weight.sv
// ----------------------------------------------------------------------------
// cbse_weight
// Computes the four window weights for one evaluation from the basis and
// the fraction, with power and coefficient multipliers, one product per cycle.
// ----------------------------------------------------------------------------
module cbse_weight #(
  parameter int unsigned CoefWidth = cbse_pkg::CoefWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [16:0]        frac_i,
  input  logic [1:0]         kind_i,
  input  logic [31:0]        basis_i [cbse_pkg::NumRegs],
  output logic               done_o,
  output logic signed [31:0] weight_o [4]
);

  localparam int unsigned CoefBits = (CoefWidth < 16) ? CoefWidth : 16;

  // step 0: f*f, step 1: t2*f, steps 2..17: coefficient * power, 4 per row
  logic [4:0]         step_q;
  logic               run_q;
  logic [16:0]        t2_q, t3_q;
  logic [16:0]        frac_q;
  logic [1:0]         kind_q;
  logic signed [47:0] acc_q;
  logic signed [31:0] w_q [4];
  logic [33:0]        sq;
  logic signed [19:0] ce;
  logic [16:0]        tp;
  logic signed [47:0] prod;
  logic [1:0]         row, col;

  function automatic logic signed [19:0] raw_coef(input logic [31:0] regs [cbse_pkg::NumRegs],
                                                  input logic [1:0] r, input logic [1:0] c);
    logic [31:0] rg;
    logic [15:0] h;
    logic [15:0] m;
    logic [15:0] hv;
    begin
      rg = regs[{r, c[1]}];
      h  = c[0] ? rg[31:16] : rg[15:0];
      m  = 16'(1) << (CoefBits - 1);
      hv = (h & ((m << 1) - 16'd1)) ^ m;
      raw_coef = 20'(signed'({4'd0, hv})) - 20'(signed'({4'd0, m}));
    end
  endfunction

  always_comb begin
    row = step_q[3:2] - 2'd2 + {1'b0, 1'b0};
    row = 2'((step_q - 5'd2) >> 2);
    col = 2'((step_q - 5'd2) & 5'd3);
    ce  = '0;
    unique case (kind_q)
      cbse_pkg::KindPos: ce = raw_coef(basis_i, row, col);
      cbse_pkg::KindTan: begin
        unique case (col)
          2'd0: ce = raw_coef(basis_i, row, 2'd1);
          2'd1: ce = raw_coef(basis_i, row, 2'd2) <<< 1;
          2'd2: ce = raw_coef(basis_i, row, 2'd3) * 20'sd3;
          default: ce = '0;
        endcase
      end
      cbse_pkg::KindCurv: begin
        unique case (col)
          2'd0: ce = raw_coef(basis_i, row, 2'd2) <<< 1;
          2'd1: ce = raw_coef(basis_i, row, 2'd3) * 20'sd6;
          default: ce = '0;
        endcase
      end
      default: ce = '0;
    endcase
    unique case (col)
      2'd0: tp = 17'd65536;
      2'd1: tp = frac_q;
      2'd2: tp = t2_q;
      default: tp = t3_q;
    endcase
    sq   = (step_q == 5'd0 ? frac_q : t2_q) * frac_q;
    prod = 48'(ce) * 48'(signed'({1'b0, tp}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd17) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      frac_q <= frac_i;
      kind_q <= kind_i;
    end else if (run_q) begin
      if (step_q == 5'd0) begin
        t2_q <= sq[32:16];
      end else if (step_q == 5'd1) begin
        t3_q <= sq[32:16];
        acc_q <= '0;
      end else begin
        if (col == 2'd3) begin
          w_q[row] <= 32'((acc_q + prod + 48'sd4096) >>> 13);
          acc_q    <= '0;
        end else begin
          acc_q <= acc_q + prod;
        end
      end
    end
  end

  assign weight_o = w_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("weight done held");
  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(run_q)) else $error("weight done without run");
  a_step_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> step_q <= 5'd17) else $error("weight step out of range");

endmodule

FILE: rtl/cubic_bspline_evaluator_unit.sv
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator_unit
// Uniform cubic B-spline evaluator over an append-only control point store.
// ----------------------------------------------------------------------------
// An append, or an evaluation on a store with fewer than four points, goes
// straight to StOut and then to its result strobe. An evaluation first
// computes the weights in cbse_weight (two powers and sixteen coefficient
// products), then makes four reads of the point memory with one
// multiply-accumulate per coordinate each, and final rounding.
// busy is high for the whole operation; results appear for one cycle on
// done_o and cannot be stalled.
module cubic_bspline_evaluator_unit #(
  parameter int unsigned MaxPoints  = cbse_pkg::MaxPoints,
  parameter int unsigned CoefWidth  = cbse_pkg::CoefWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [26:0] curve_param_i,
  input  logic [1:0]  eval_kind_i,
  output logic        done_o,
  output logic [31:0] result_x_o,
  output logic [31:0] result_y_o,
  output logic [31:0] result_z_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CoordWidth = cbse_pkg::CoordWidth;
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW  = AddrW + 1;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StWgt   = 5'b00010,
    StMac   = 5'b00100,
    StRound = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] basis_q [cbse_pkg::NumRegs];
  logic [CntW-1:0] count_q;
  logic [3*CoordWidth-1:0] mem [MaxPoints];
  logic [3*CoordWidth-1:0] rd_q;
  logic [AddrW-1:0] win_q;
  logic [2:0] idx_q;
  logic rd_vld_q;
  logic [16:0] frac_d;
  logic [AddrW-1:0] win_d;
  logic wstart;
  logic wdone;
  logic signed [31:0] w [4];
  logic signed [95:0] acc_q [3];
  logic signed [31:0] res_q [3];
  logic [1:0] stat_q;
  logic done_q;

  cbse_weight #(.CoefWidth(CoefWidth)) u_weight (
    .clk_i, .rst_ni, .start_i(wstart), .frac_i(frac_d), .kind_i(eval_kind_i),
    .basis_i(basis_q), .done_o(wdone), .weight_o(w)
  );

  assign pready = 1'b1;
  assign prdata = basis_q[paddr[4:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q <= cbse_pkg::BasisReset;
    end else if (psel && penable && pwrite) begin
      basis_q[paddr[4:2]] <= pwdata;
    end
  end

  // Window and fraction from t, clamped.
  always_comb begin
    logic [25:0] tt;
    logic [CntW-1:0] lastw;
    logic [9:0] fl;
    tt = curve_param_i[26] ? 26'd0 : curve_param_i[25:0];
    fl = tt[25:16];
    lastw = count_q - CntW'(4);
    if (CntW'(fl) > lastw || (CntW < 10 && |(fl >> (CntW > 10 ? 10 : CntW)))) begin
      win_d  = lastw[AddrW-1:0];
      frac_d = 17'd65536;
    end else begin
      win_d  = AddrW'(fl);
      frac_d = {1'b0, tt[15:0]};
    end
  end

  assign busy   = (state_q != StIdle);
  assign wstart = start && !busy && action_i != cbse_pkg::ActAppend
                  && count_q >= CntW'(4);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (wstart) state_d = StWgt;
               else if (start) state_d = StOut;
      StWgt:   if (wdone) state_d = StMac;
      StMac:   if (idx_q == 3'd4 && !rd_vld_q) state_d = StRound;
      StRound: state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      done_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StOut);
      if (start && !busy && action_i == cbse_pkg::ActAppend
          && count_q < CntW'(MaxPoints)) begin
        count_q <= count_q + CntW'(1);
      end
      if (wdone) idx_q <= '0;
      rd_vld_q <= 1'b0;
      if (state_q == StMac && idx_q < 3'd4 && !rd_vld_q) begin
        rd_vld_q <= 1'b1;
        idx_q    <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy && action_i == cbse_pkg::ActAppend && count_q < CntW'(MaxPoints))
      mem[count_q[AddrW-1:0]] <= {point_z_i[CoordWidth-1:0], point_y_i[CoordWidth-1:0],
                                  point_x_i[CoordWidth-1:0]};
    rd_q <= mem[win_q + AddrW'(idx_q)];
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      win_q <= win_d;
      for (int c = 0; c < 3; c++) res_q[c] <= '0;
      acc_q <= '{default: '0};
      if (action_i == cbse_pkg::ActAppend)
        stat_q <= (count_q < CntW'(MaxPoints)) ? cbse_pkg::StatusAppend
                                                : cbse_pkg::StatusFull;
      else
        stat_q <= (count_q >= CntW'(4)) ? cbse_pkg::StatusEval : cbse_pkg::StatusFew;
    end
    if (rd_vld_q) begin
      for (int c = 0; c < 3; c++)
        acc_q[c] <= acc_q[c] + 96'(signed'(rd_q[c*CoordWidth +: CoordWidth]))
                    * 96'(w[idx_q[1:0] - 2'd1]);
    end
    if (state_q == StRound) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [95:0] r;
        r = (acc_q[c] + 96'sd32768) >>> 16;
        if (r > 96'sd2147483647 >>> (32 - CoordWidth))
          res_q[c] <= 32'(96'sd2147483647 >>> (32 - CoordWidth));
        else if (r < -(96'sd2147483648 >>> (32 - CoordWidth)))
          res_q[c] <= 32'(-(96'sd2147483648 >>> (32 - CoordWidth)));
        else
          res_q[c] <= 32'(r);
      end
    end
  end

  assign done_o     = done_q;
  assign result_x_o = res_q[0];
  assign result_y_o = res_q[1];
  assign result_z_o = res_q[2];
  assign status_o   = stat_q;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(state_q == StOut)) else $error("overlapping result");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints)) else $error("point count overflow");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

endmodule

FILE: sim/cubic_bspline_evaluator_unit_tb.sv
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator_unit_tb
// Drives appends and evaluations through the command port and programs the
// basis over APB. Every result strobe is checked against a spline predictor.
// ----------------------------------------------------------------------------
module cubic_bspline_evaluator_unit_tb;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
  } spline_out_t;

  class spline_scoreboard;
    logic [31:0]  basis [cbse_pkg::NumRegs];
    longint       points [cbse_pkg::MaxPoints][3];
    int unsigned  npoints;
    spline_out_t  expected_q [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  evals;

    function new();
      for (int i = 0; i < cbse_pkg::NumRegs; i++) basis[i] = cbse_pkg::BasisReset[i];
      npoints    = 0;
      mismatches = 0;
      checked    = 0;
      evals      = 0;
    endfunction

    function longint coef(int row, int col);
      logic [31:0] r;
      logic signed [15:0] h;
      r = basis[row * 2 + col / 2];
      h = (col % 2) ? r[31:16] : r[15:0];
      return longint'(h);
    endfunction

    function longint kind_coef(logic [1:0] kind, int row, int col);
      case (kind)
        cbse_pkg::KindPos:  return coef(row, col);
        cbse_pkg::KindTan: begin
          if (col == 0) return coef(row, 1);
          if (col == 1) return 2 * coef(row, 2);
          if (col == 2) return 3 * coef(row, 3);
          return 0;
        end
        cbse_pkg::KindCurv: begin
          if (col == 0) return 2 * coef(row, 2);
          if (col == 1) return 6 * coef(row, 3);
          return 0;
        end
        default: return 0;
      endcase
    endfunction

    function void note_item(logic act, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [26:0] tp, logic [1:0] kind);
      spline_out_t e;
      longint t, f, win, acc, ph, pl, r;
      longint tv [4];
      longint w [4];
      longint hi [3];
      longint lo [3];
      e = '{x: '0, y: '0, z: '0, status: cbse_pkg::StatusEval};
      if (act == cbse_pkg::ActAppend) begin
        if (npoints < cbse_pkg::MaxPoints) begin
          points[npoints][0] = longint'(signed'(px));
          points[npoints][1] = longint'(signed'(py));
          points[npoints][2] = longint'(signed'(pz));
          npoints++;
          e.status = cbse_pkg::StatusAppend;
        end else begin
          e.status = cbse_pkg::StatusFull;
        end
      end else if (npoints < 4) begin
        e.status = cbse_pkg::StatusFew;
      end else begin
        evals++;
        t = longint'(signed'(tp));
        if (t < 0) t = 0;
        win = t >>> 16;
        f   = t & 64'hFFFF;
        if (win > npoints - 4) begin
          win = npoints - 4;
          f   = 65536;
        end
        tv[0] = 65536;
        tv[1] = f;
        tv[2] = (f * f) >>> 16;
        tv[3] = (tv[2] * f) >>> 16;
        for (int i = 0; i < 4; i++) begin
          acc = 0;
          for (int j = 0; j < 4; j++) acc += kind_coef(kind, i, j) * tv[j];
          w[i] = (acc + 4096) >>> 13;
        end
        for (int c = 0; c < 3; c++) begin
          hi[c] = 0;
          lo[c] = 0;
        end
        // split each coordinate so the partial sums stay well inside 64 bits
        for (int i = 0; i < 4; i++) begin
          for (int c = 0; c < 3; c++) begin
            ph = points[win + i][c] >>> 16;
            pl = points[win + i][c] - ph * 65536;
            hi[c] += ph * w[i];
            lo[c] += pl * w[i];
          end
        end
        for (int c = 0; c < 3; c++) begin
          r = hi[c] + ((lo[c] + 32768) >>> 16);
          if (r > 64'sd2147483647) r = 64'sd2147483647;
          if (r < -64'sd2147483648) r = -64'sd2147483648;
          if (c == 0) e.x = r[31:0];
          else if (c == 1) e.y = r[31:0];
          else e.z = r[31:0];
        end
      end
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(spline_out_t got);
      spline_out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: status %0d", got.status);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%h y=%h z=%h st=%0d  got x=%h y=%h z=%h st=%0d",
                   e.x, e.y, e.z, e.status, got.x, got.y, got.z, got.status);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        action_i = 1'b0;
  logic [31:0] point_x_i = '0;
  logic [31:0] point_y_i = '0;
  logic [31:0] point_z_i = '0;
  logic [26:0] curve_param_i = '0;
  logic [1:0]  eval_kind_i = '0;
  logic        done_o;
  logic [31:0] result_x_o;
  logic [31:0] result_y_o;
  logic [31:0] result_z_o;
  logic [1:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  spline_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  cubic_bspline_evaluator_unit dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{x: result_x_o, y: result_y_o, z: result_z_o, status: status_o});
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [26:0] tp, logic [1:0] kind);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
    start         <= 1'b1;
    action_i      <= act;
    point_x_i     <= px;
    point_y_i     <= py;
    point_z_i     <= pz;
    curve_param_i <= tp;
    eval_kind_i   <= kind;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(act, px, py, pz, tp, kind);
  endtask

  task automatic append_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_item(cbse_pkg::ActAppend, px, py, pz, 27'($urandom), 2'($urandom));
  endtask

  task automatic evaluate(logic [26:0] tp, logic [1:0] kind);
    send_item(~cbse_pkg::ActAppend, $urandom, $urandom, $urandom, tp, kind);
  endtask

  // drop start, drain every expected transfer, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_basis(int idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.basis[idx] = value;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_coord();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2097152)) - 1048576);
  endfunction

  task automatic random_items(int unsigned n);
    logic [26:0] tp;
    for (int unsigned k = 0; k < n; k++) begin
      if (sb.npoints < 4 || (sb.npoints < 900 && $urandom_range(0, 99) < 35)) begin
        append_point(random_coord(), random_coord(), random_coord());
      end else begin
        case ($urandom_range(0, 6))
          0:       tp = 27'($urandom);
          1:       tp = 27'(-$signed({1'b0, $urandom_range(1, 1 << 20)}));
          default: tp = 27'($urandom_range(0, (sb.npoints - 3) * 65536));
        endcase
        evaluate(tp, ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, coordinate extremes, all kinds, clamped parameters
    evaluate(27'd65536, cbse_pkg::KindPos);
    append_point(32'h7FFFFFFF, 32'h80000000, 32'h00000000);
    append_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    append_point(32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
    evaluate(27'd0, cbse_pkg::KindPos);
    append_point(32'hFFFFFFFF, 32'h00000001, 32'h80000000);
    append_point(32'h00000000, 32'h12345678, 32'hEDCBA987);
    evaluate(27'd0, cbse_pkg::KindPos);
    evaluate(27'd32768, cbse_pkg::KindTan);
    evaluate(27'd65535, cbse_pkg::KindCurv);
    evaluate(27'd98304, 2'd3);
    evaluate(27'h4000000, cbse_pkg::KindPos);
    evaluate(27'h7FFFFFF, cbse_pkg::KindTan);
    evaluate(27'h3FFFFFF, cbse_pkg::KindPos);
    evaluate(27'h3FFFFFF, cbse_pkg::KindCurv);
    evaluate(27'd65536, cbse_pkg::KindTan);
    evaluate(27'd131071, cbse_pkg::KindCurv);
    drain();
    random_items(200);

    for (int i = 0; i < cbse_pkg::NumRegs; i++) write_basis(i, $urandom);
    random_items(180);
    for (int i = 0; i < cbse_pkg::NumRegs; i++) write_basis(i, 32'h7FFF7FFF);
    random_items(80);
    for (int i = 0; i < cbse_pkg::NumRegs; i++) write_basis(i, 32'h80008000);
    random_items(80);
    for (int i = 0; i < cbse_pkg::NumRegs; i++) write_basis(i, cbse_pkg::BasisReset[i]);
    random_items(90);

    // evaluate past the end of the store
    evaluate(27'((cbse_pkg::MaxPoints - 4) * 65536 + 40000), cbse_pkg::KindPos);
    evaluate(27'h3FFFFFF, cbse_pkg::KindTan);
    evaluate(27'h4000000, cbse_pkg::KindCurv);
    drain();

    $display("checked %0d result transfers, %0d of them spline evaluations, over 5 basis settings",
             sb.checked, sb.evals);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cbse_pkg.sv
rtl/cbse_weight.sv
rtl/cubic_bspline_evaluator_unit.sv
sim/cubic_bspline_evaluator_unit_tb.sv
